>>> hdl/assert_macros.svh
// assertion helpers used by owtr_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define OWTR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owtr check failed");

// next-cycle implication, disabled while reset is active
`define OWTR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owtr check failed");

`endif

>>> hdl/owtr_pkg.sv
`default_nettype none

package owtr_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int TICK_W        = 20;
  localparam int DUR_W         = 20;
  localparam int CNT_W         = TICK_W + 1;
  localparam int CMP_W         = (CNT_W > DUR_W) ? CNT_W : DUR_W;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int CFG_DATA_W    = 20;
  localparam int CFG_IDX_W     = 3;
  localparam int TEMP_W        = 16;

  localparam logic [CNT_W-1:0] TICK_MAX = CNT_W'((64'd1 << TICK_W) - 64'd1);

  // register reset values
  localparam logic [9:0]  RST_RESET_LOW   = 10'd600;
  localparam logic [7:0]  RST_PRES_WAIT   = 8'd60;
  localparam logic [7:0]  RST_RESET_RECOV = 8'd100;
  localparam logic [3:0]  RST_SLOT_START  = 4'd2;
  localparam logic [7:0]  RST_SLOT_DATA   = 8'd60;
  localparam logic [5:0]  RST_SLOT_RECOV  = 6'd10;
  localparam logic [19:0] RST_CONV_WAIT   = 20'd500000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW   = 3'd0,
    CFG_PRES_WAIT   = 3'd1,
    CFG_RESET_RECOV = 3'd2,
    CFG_SLOT_START  = 3'd3,
    CFG_SLOT_DATA   = 3'd4,
    CFG_SLOT_RECOV  = 3'd5,
    CFG_CONV_WAIT   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_WAIT   = 4'd2,
    PH_RST_SAMPLE = 4'd3,
    PH_RST_RECOV  = 4'd4,
    PH_SLOT_START = 4'd5,
    PH_WR_DATA    = 4'd6,
    PH_RD_SAMPLE  = 4'd7,
    PH_RD_WAIT    = 4'd8,
    PH_SLOT_RECOV = 4'd9,
    PH_CONV_WAIT  = 4'd10
  } phase_e;

  // byte steps of the sequence
  localparam logic [2:0] STEP_SKIP_A   = 3'd0;
  localparam logic [2:0] STEP_CONVERT  = 3'd1;
  localparam logic [2:0] STEP_SKIP_B   = 3'd2;
  localparam logic [2:0] STEP_READ_CMD = 3'd3;
  localparam logic [2:0] STEP_RD_LSB   = 3'd4;
  localparam logic [2:0] STEP_RD_MSB   = 3'd5;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  typedef struct packed {
    logic [9:0]  reset_low;
    logic [7:0]  pres_wait;
    logic [7:0]  reset_recov;
    logic [3:0]  slot_start;
    logic [7:0]  slot_data;
    logic [5:0]  slot_recov;
    logic [19:0] conv_wait;
  } owtr_cfg_t;

  typedef struct packed {
    logic              dq_enable;
    logic              dq_level;
    logic              busy;
    logic              done;
    logic [TEMP_W-1:0] tenths;
    logic              presence;
  } owtr_res_t;

  function automatic logic [7:0] cmd_byte(input logic [2:0] step);
    logic [7:0] b;
    case (step)
      STEP_SKIP_A:   b = CMD_SKIP_ROM;
      STEP_CONVERT:  b = CMD_CONVERT;
      STEP_SKIP_B:   b = CMD_SKIP_ROM;
      STEP_READ_CMD: b = CMD_READ_SP;
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/owtr_seq.sv
`default_nettype none

module owtr_seq import owtr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       start_req_i,
  input  wire logic       dq_sample_i,
  input  wire owtr_cfg_t  cfg_i,
  output owtr_res_t       res_o
);

  phase_e                 phase_q, phase_d, eff_phase;
  logic [TICK_W-1:0]      tick_q, tick_d, eff_tick;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d, eff_bit;
  logic [2:0]             byte_q, byte_d, eff_byte;
  logic [7:0]             shift_q, shift_d;
  logic [15:0]            raw_q, raw_d;
  logic [TEMP_W-1:0]      tenths_q, tenths_d;
  logic                   pres_q, pres_d;

  logic                   en, lvl, busy, done;
  logic [DUR_W-1:0]       dur;
  logic [CNT_W-1:0]       cnt;
  logic                   advance;
  logic [15:0]            raw_full;
  logic [19:0]            scaled;
  logic                   pres_now;

  // a start seen in idle opens the reset pulse on this same tick
  always_comb begin
    eff_phase = phase_q;
    eff_tick  = tick_q;
    eff_bit   = bit_q;
    eff_byte  = byte_q;
    if (phase_q == PH_IDLE && start_req_i) begin
      eff_phase = PH_RST_LOW;
      eff_tick  = '0;
      eff_bit   = '0;
      eff_byte  = STEP_SKIP_A;
    end
  end

  // bus drive and phase length
  always_comb begin
    en   = 1'b0;
    lvl  = 1'b1;
    busy = 1'b1;
    dur  = DUR_W'(1);
    case (eff_phase)
      PH_IDLE:       busy = 1'b0;
      PH_RST_LOW:    begin en = 1'b1; lvl = 1'b0; dur = DUR_W'(cfg_i.reset_low); end
      PH_RST_WAIT:   dur = DUR_W'(cfg_i.pres_wait);
      PH_RST_SAMPLE: dur = DUR_W'(1);
      PH_RST_RECOV:  begin en = 1'b1; dur = DUR_W'(cfg_i.reset_recov); end
      PH_SLOT_START: begin en = 1'b1; lvl = 1'b0; dur = DUR_W'(cfg_i.slot_start); end
      PH_WR_DATA:    begin en = 1'b1; lvl = shift_q[0]; dur = DUR_W'(cfg_i.slot_data); end
      PH_RD_SAMPLE:  dur = DUR_W'(1);
      PH_RD_WAIT:    dur = DUR_W'(cfg_i.slot_data);
      PH_SLOT_RECOV: begin en = 1'b1; dur = DUR_W'(cfg_i.slot_recov); end
      PH_CONV_WAIT:  begin en = 1'b1; dur = cfg_i.conv_wait; end
      default:       busy = 1'b0;
    endcase
  end

  // saturating tick count, hitting the ceiling also ends the phase
  always_comb begin
    cnt = CNT_W'(eff_tick) + CNT_W'(1);
    if (cnt > TICK_MAX) begin
      cnt = TICK_MAX;
    end
    advance = !(CMP_W'(cnt) < CMP_W'(dur)) || (cnt == TICK_MAX);
  end

  assign pres_now = ~dq_sample_i;
  assign raw_full = {shift_q, raw_q[7:0]};
  // raw * 10 + 8, then drop four bits
  assign scaled   = (20'(raw_full) << 3) + (20'(raw_full) << 1) + 20'd8;

  always_comb begin
    phase_d  = eff_phase;
    tick_d   = eff_tick;
    bit_d    = eff_bit;
    byte_d   = eff_byte;
    shift_d  = shift_q;
    raw_d    = raw_q;
    tenths_d = tenths_q;
    pres_d   = pres_q;
    done     = 1'b0;
    if (eff_phase != PH_IDLE) begin
      if (!advance) begin
        tick_d = cnt[TICK_W-1:0];
      end else begin
        tick_d = '0;
        case (eff_phase)
          PH_RST_LOW:    phase_d = PH_RST_WAIT;
          PH_RST_WAIT:   phase_d = PH_RST_SAMPLE;
          PH_RST_SAMPLE: begin
            pres_d  = (eff_byte == STEP_SKIP_A) ? pres_now : (pres_q & pres_now);
            phase_d = PH_RST_RECOV;
          end
          PH_RST_RECOV: begin
            shift_d = cmd_byte(eff_byte);
            bit_d   = '0;
            phase_d = PH_SLOT_START;
          end
          PH_SLOT_START: phase_d = (eff_byte >= STEP_RD_LSB) ? PH_RD_SAMPLE : PH_WR_DATA;
          PH_WR_DATA: begin
            shift_d = {1'b0, shift_q[7:1]};
            phase_d = PH_SLOT_RECOV;
          end
          PH_RD_SAMPLE: begin
            shift_d = {dq_sample_i, shift_q[7:1]};
            phase_d = PH_RD_WAIT;
          end
          PH_RD_WAIT: phase_d = PH_SLOT_RECOV;
          PH_SLOT_RECOV: begin
            if (eff_bit != BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
              bit_d   = eff_bit + BIT_IDX_W'(1);
              phase_d = PH_SLOT_START;
            end else begin
              bit_d = '0;
              case (eff_byte)
                STEP_SKIP_A: begin
                  byte_d  = STEP_CONVERT;
                  shift_d = cmd_byte(STEP_CONVERT);
                  phase_d = PH_SLOT_START;
                end
                STEP_CONVERT: begin
                  byte_d  = STEP_SKIP_B;
                  phase_d = PH_CONV_WAIT;
                end
                STEP_SKIP_B: begin
                  byte_d  = STEP_READ_CMD;
                  shift_d = cmd_byte(STEP_READ_CMD);
                  phase_d = PH_SLOT_START;
                end
                STEP_READ_CMD: begin
                  byte_d  = STEP_RD_LSB;
                  shift_d = '0;
                  phase_d = PH_SLOT_START;
                end
                STEP_RD_LSB: begin
                  raw_d   = {raw_q[15:8], shift_q};
                  byte_d  = STEP_RD_MSB;
                  shift_d = '0;
                  phase_d = PH_SLOT_START;
                end
                STEP_RD_MSB: begin
                  raw_d    = raw_full;
                  tenths_d = scaled[19:4];
                  done     = 1'b1;
                  phase_d  = PH_IDLE;
                end
                default: phase_d = PH_IDLE;
              endcase
            end
          end
          PH_CONV_WAIT: phase_d = PH_RST_LOW;
          default:      phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      byte_q   <= '0;
      shift_q  <= '0;
      raw_q    <= '0;
      tenths_q <= '0;
      pres_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      byte_q   <= byte_d;
      shift_q  <= shift_d;
      raw_q    <= raw_d;
      tenths_q <= tenths_d;
      pres_q   <= pres_d;
    end
  end

  assign res_o.dq_enable = en;
  assign res_o.dq_level  = lvl;
  assign res_o.busy      = busy;
  assign res_o.done      = done;
  assign res_o.tenths    = tenths_d;
  assign res_o.presence  = pres_d;

endmodule

`default_nettype wire

>>> hdl/one_wire_temperature_reader.sv
// one-wire master that reads a temperature sensor, one bus tick per input word
//
// input channel (in_valid_i / in_ready_o): each word is one tick, carrying
//   start_req_i and the sampled bus level dq_sample_i
// output channel (out_valid_o / out_ready_i): one word per input word, with
//   the bus drive for that tick, busy/done flags, the temperature in tenths
//   of a degree and the presence flag
// config port: cfg_we_i writes cfg_wdata_i into the timing register selected
//   by cfg_index_i on the same edge; indexes past the last register are dropped
// result: an accepted word's output is registered on the accepting edge
// throughput: one word per cycle unless stalled; the sequencer step sits
//   between the state registers and a single output register, so in_ready_o
//   stays high while the output register is empty or being drained this cycle
// stall: when the receiver holds out_ready_i low with a word pending, the
//   output word holds and in_ready_o drops until it is taken
// reset: rst_ni low clears the sequencer to idle, the result and presence to
//   zero, empties the output register and loads the default timings
`default_nettype none

module one_wire_temperature_reader import owtr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  start_req_i,
  input  wire logic                  dq_sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       dq_enable_o,
  output logic                       dq_level_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic [TEMP_W-1:0]          temperature_tenths_o,
  output logic                       presence_ok_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  owtr_cfg_t cfg_q;
  owtr_res_t res;
  owtr_res_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      accept;

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low   <= RST_RESET_LOW;
      cfg_q.pres_wait   <= RST_PRES_WAIT;
      cfg_q.reset_recov <= RST_RESET_RECOV;
      cfg_q.slot_start  <= RST_SLOT_START;
      cfg_q.slot_data   <= RST_SLOT_DATA;
      cfg_q.slot_recov  <= RST_SLOT_RECOV;
      cfg_q.conv_wait   <= RST_CONV_WAIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RESET_LOW:   cfg_q.reset_low   <= cfg_wdata_i[9:0];
        CFG_PRES_WAIT:   cfg_q.pres_wait   <= cfg_wdata_i[7:0];
        CFG_RESET_RECOV: cfg_q.reset_recov <= cfg_wdata_i[7:0];
        CFG_SLOT_START:  cfg_q.slot_start  <= cfg_wdata_i[3:0];
        CFG_SLOT_DATA:   cfg_q.slot_data   <= cfg_wdata_i[7:0];
        CFG_SLOT_RECOV:  cfg_q.slot_recov  <= cfg_wdata_i[5:0];
        CFG_CONV_WAIT:   cfg_q.conv_wait   <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // take a new tick whenever the output register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // sequencer advances only on an accepted tick
  owtr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .start_req_i (start_req_i),
    .dq_sample_i (dq_sample_i),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign dq_enable_o          = out_q.dq_enable;
  assign dq_level_o           = out_q.dq_level;
  assign busy_res_o           = out_q.busy;
  assign done_res_o           = out_q.done;
  assign temperature_tenths_o = out_q.tenths;
  assign presence_ok_o        = out_q.presence;

endmodule

`default_nettype wire

>>> hdl/owtr_checker.sv
`default_nettype none

`include "assert_macros.svh"

module owtr_checker import owtr_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic                  busy_res_o,
  input wire logic                  done_res_o
);

  // a pending word is never dropped
  `OWTR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // an accepted tick always yields a word on the next cycle
  `OWTR_ASSERT_NEXT(a_accept_out, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)
  // no overrun of a stalled output word
  `OWTR_ASSERT_NOW(a_no_overrun, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o)
  // an empty output never blocks the input
  `OWTR_ASSERT_NOW(a_ready_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // the done tick belongs to a sequence
  `OWTR_ASSERT_NOW(a_done_busy, clk_i, rst_ni, out_valid_o && done_res_o, busy_res_o)

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o)
);

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
  import owtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int RANDOM_TICKS   = 300;   // tick words in the random-timing phase
  localparam int CHUNK          = 16;    // tick words queued per refill while a read runs
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 4;     // margin after the last output word is taken
  localparam int QUIET_FROM     = 300;   // cycle window with no idling on either side
  localparam int QUIET_TO       = 700;

  // bus level that the simulated sensor returns on every tick
  localparam int DQ_LOW    = 0;
  localparam int DQ_HIGH   = 1;
  localparam int DQ_RANDOM = 2;

  // register index past the last timing register, must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic start;
    logic dq;
  } tick_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all at known values from time zero
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  start_req  = 1'b0;
  logic                  dq_sample  = 1'b1;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  dq_enable;
  logic                  dq_level;
  logic                  busy_res;
  logic                  done_res;
  logic [TEMP_W-1:0]     temperature_tenths;
  logic                  presence_ok;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  always #2 clk_i = ~clk_i;

  one_wire_temperature_reader dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .start_req_i          (start_req),
    .dq_sample_i          (dq_sample),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .dq_enable_o          (dq_enable),
    .dq_level_o           (dq_level),
    .busy_res_o           (busy_res),
    .done_res_o           (done_res),
    .temperature_tenths_o (temperature_tenths),
    .presence_ok_o        (presence_ok),
    .cfg_we_i             (cfg_we),
    .cfg_index_i          (cfg_index),
    .cfg_wdata_i          (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // bookkeeping shared by the stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  tick_t      tick_q[$];           // tick words not yet offered to the block
  owtr_res_t  tick_results_q[$];   // predicted output words, oldest first
  int unsigned pushed_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned mismatch_count = 0;
  int unsigned reading_count  = 0;
  int unsigned setting_count  = 0;
  int unsigned cycle_count    = 0;
  int unsigned quiet_cycles   = 0;
  logic        in_fire        = 1'b0;   // input word taken at the last rising edge

  // ---------------------------------------------------------------------------
  // sequencer copy: timing registers and state after every accepted tick
  // ---------------------------------------------------------------------------
  owtr_cfg_t              timing;
  phase_e                 seq_phase     = PH_IDLE;
  logic [TICK_W-1:0]      tick_cnt      = '0;
  logic [BIT_IDX_W-1:0]   bit_pos       = '0;
  logic [2:0]             byte_step     = STEP_SKIP_A;
  logic [7:0]             shreg         = '0;
  logic [15:0]            raw_reading   = '0;
  logic [TEMP_W-1:0]      tenths_reg    = '0;
  logic                   presence_flag = 1'b0;

  initial begin
    timing.reset_low   = RST_RESET_LOW;
    timing.pres_wait   = RST_PRES_WAIT;
    timing.reset_recov = RST_RESET_RECOV;
    timing.slot_start  = RST_SLOT_START;
    timing.slot_data   = RST_SLOT_DATA;
    timing.slot_recov  = RST_SLOT_RECOV;
    timing.conv_wait   = RST_CONV_WAIT;
  end

  // command byte sent at the current byte step, lsb goes out first
  function automatic void load_next_command();
    case (byte_step)
      STEP_SKIP_A, STEP_SKIP_B: shreg = CMD_SKIP_ROM;
      STEP_CONVERT:             shreg = CMD_CONVERT;
      STEP_READ_CMD:            shreg = CMD_READ_SP;
      default:                  shreg = 8'h00;
    endcase
    bit_pos = '0;
  endfunction

  // one bus tick: returns the output word and advances the sequencer copy
  function automatic owtr_res_t step_sequencer(logic start, logic dq);
    owtr_res_t        r;
    logic [CNT_W-1:0] cnt;
    logic [DUR_W-1:0] dur;
    logic [19:0]      scaled;
    r        = '0;
    r.dq_level = 1'b1;
    dur      = DUR_W'(1);
    // start is only seen while idle, its tick is the first reset-low tick
    if (seq_phase == PH_IDLE && start) begin
      seq_phase = PH_RST_LOW;
      tick_cnt  = '0;
      byte_step = STEP_SKIP_A;
      bit_pos   = '0;
    end
    if (seq_phase != PH_IDLE) begin
      r.busy = 1'b1;
      case (seq_phase)
        PH_RST_LOW: begin
          r.dq_enable = 1'b1; r.dq_level = 1'b0; dur = DUR_W'(timing.reset_low);
        end
        PH_RST_WAIT:   dur = DUR_W'(timing.pres_wait);
        PH_RST_SAMPLE: dur = DUR_W'(1);
        PH_RST_RECOV:  begin r.dq_enable = 1'b1; dur = DUR_W'(timing.reset_recov); end
        PH_SLOT_START: begin
          r.dq_enable = 1'b1; r.dq_level = 1'b0; dur = DUR_W'(timing.slot_start);
        end
        PH_WR_DATA: begin
          r.dq_enable = 1'b1; r.dq_level = shreg[0]; dur = DUR_W'(timing.slot_data);
        end
        PH_RD_SAMPLE:  dur = DUR_W'(1);
        PH_RD_WAIT:    dur = DUR_W'(timing.slot_data);
        PH_SLOT_RECOV: begin r.dq_enable = 1'b1; dur = DUR_W'(timing.slot_recov); end
        PH_CONV_WAIT:  begin r.dq_enable = 1'b1; dur = timing.conv_wait; end
        default:       begin seq_phase = PH_IDLE; r.busy = 1'b0; end
      endcase
    end
    if (seq_phase != PH_IDLE) begin
      // counter saturates, and a zero duration ends the phase after one tick
      cnt = {1'b0, tick_cnt} + 1'b1;
      if (cnt > TICK_MAX) cnt = TICK_MAX;
      if (cnt < dur && cnt != TICK_MAX) begin
        tick_cnt = cnt[TICK_W-1:0];
      end else begin
        tick_cnt = '0;
        case (seq_phase)
          PH_RST_LOW:    seq_phase = PH_RST_WAIT;
          PH_RST_WAIT:   seq_phase = PH_RST_SAMPLE;
          PH_RST_SAMPLE: begin
            // first reset sets presence, the second one can only clear it
            presence_flag = (byte_step == STEP_SKIP_A) ? !dq : (presence_flag & !dq);
            seq_phase     = PH_RST_RECOV;
          end
          PH_RST_RECOV: begin
            load_next_command();
            seq_phase = PH_SLOT_START;
          end
          PH_SLOT_START: seq_phase = (byte_step >= STEP_RD_LSB) ? PH_RD_SAMPLE : PH_WR_DATA;
          PH_WR_DATA: begin
            shreg     = shreg >> 1;
            seq_phase = PH_SLOT_RECOV;
          end
          PH_RD_SAMPLE: begin
            shreg     = {dq, shreg[7:1]};
            seq_phase = PH_RD_WAIT;
          end
          PH_RD_WAIT: seq_phase = PH_SLOT_RECOV;
          PH_SLOT_RECOV: begin
            if (bit_pos < BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
              bit_pos   = bit_pos + 1'b1;
              seq_phase = PH_SLOT_START;
            end else begin
              bit_pos = '0;
              case (byte_step)
                STEP_SKIP_A: begin
                  byte_step = STEP_CONVERT;
                  load_next_command();
                  seq_phase = PH_SLOT_START;
                end
                STEP_CONVERT: begin
                  byte_step = STEP_SKIP_B;
                  seq_phase = PH_CONV_WAIT;
                end
                STEP_SKIP_B: begin
                  byte_step = STEP_READ_CMD;
                  load_next_command();
                  seq_phase = PH_SLOT_START;
                end
                STEP_READ_CMD: begin
                  byte_step = STEP_RD_LSB;
                  shreg     = '0;
                  seq_phase = PH_SLOT_START;
                end
                STEP_RD_LSB: begin
                  raw_reading[7:0] = shreg;
                  byte_step        = STEP_RD_MSB;
                  shreg            = '0;
                  seq_phase        = PH_SLOT_START;
                end
                STEP_RD_MSB: begin
                  // raw * 0.625, rounded half up, no sign handling
                  raw_reading[15:8] = shreg;
                  scaled            = {4'b0, raw_reading} * 20'd10 + 20'd8;
                  tenths_reg        = scaled[19:4];
                  r.done            = 1'b1;
                  seq_phase         = PH_IDLE;
                end
                default: seq_phase = PH_IDLE;
              endcase
            end
          end
          PH_CONV_WAIT: seq_phase = PH_RST_LOW;
          default:      seq_phase = PH_IDLE;
        endcase
      end
    end
    r.tenths   = tenths_reg;
    r.presence = presence_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers tick words and output ready at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    tick_t item;
    logic  idling;
    // idling is off inside one long window of the run
    idling = !(cycle_count >= QUIET_FROM && cycle_count < QUIET_TO);
    if (rst_n) begin
      // a word already offered stays put until it is taken
      if (!in_valid || in_fire) begin
        if (tick_q.size() > 0 && !(idling && $urandom_range(99) < 8)) begin
          item      = tick_q.pop_front();
          in_valid  <= 1'b1;
          start_req <= item.start;
          dq_sample <= item.dq;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !(idling && $urandom_range(99) < 8);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted tick word, checks every output word
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("word %0d: %s expected %0d, got %0d", result_count, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    owtr_res_t want;
    if (rst_n) begin
      cycle_count++;
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("word %0d: output word with no tick word behind it", result_count);
        end else begin
          want = tick_results_q.pop_front();
          check_field("dq_enable", want.dq_enable, dq_enable);
          check_field("dq_level", want.dq_level, dq_level);
          check_field("busy_res", want.busy, busy_res);
          check_field("done_res", want.done, done_res);
          check_field("temperature_tenths", want.tenths, temperature_tenths);
          check_field("presence_ok", want.presence, presence_ok);
        end
        if (done_res) reading_count++;
        result_count++;
      end
      // predict after the output check, the new word shows up next cycle at the earliest
      if (in_valid && in_ready) begin
        tick_results_q.push_back(step_sequencer(start_req, dq_sample));
        accepted_count++;
      end
      in_fire <= in_valid && in_ready;
    end
  end

  // watchdog: nothing moving on either side for too long ends the run
  always @(posedge clk_i) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_tick(logic s, logic d);
    tick_q.push_back('{start: s, dq: d});
    pushed_count++;
  endtask

  // low bits carry the value, bits above the register width are random junk
  function automatic logic [CFG_DATA_W-1:0] pad_word(int unsigned v, int unsigned w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << w) - 1'b1;
    return (CFG_DATA_W'($urandom()) & ~mask) | (CFG_DATA_W'(v) & mask);
  endfunction

  // write every timing register plus the unused index, no tick word in flight
  task automatic program_timing(owtr_cfg_t t);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RESET_LOW;
    cfg_wdata <= pad_word(t.reset_low, 10);
    @(negedge clk_i);
    cfg_index <= CFG_PRES_WAIT;
    cfg_wdata <= pad_word(t.pres_wait, 8);
    @(negedge clk_i);
    cfg_index <= CFG_RESET_RECOV;
    cfg_wdata <= pad_word(t.reset_recov, 8);
    @(negedge clk_i);
    cfg_index <= CFG_SLOT_START;
    cfg_wdata <= pad_word(t.slot_start, 4);
    @(negedge clk_i);
    cfg_index <= CFG_SLOT_DATA;
    cfg_wdata <= pad_word(t.slot_data, 8);
    @(negedge clk_i);
    cfg_index <= CFG_SLOT_RECOV;
    cfg_wdata <= pad_word(t.slot_recov, 6);
    @(negedge clk_i);
    cfg_index <= CFG_CONV_WAIT;
    cfg_wdata <= pad_word(t.conv_wait, 20);
    @(negedge clk_i);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= CFG_DATA_W'($urandom());
    @(negedge clk_i);
    cfg_we <= 1'b0;
    timing = t;
    setting_count++;
  endtask

  // short timings keep a full read near a few hundred ticks
  function automatic owtr_cfg_t random_timing();
    owtr_cfg_t t;
    t.reset_low   = 10'($urandom_range(0, 4));
    t.pres_wait   = 8'($urandom_range(0, 3));
    t.reset_recov = 8'($urandom_range(0, 3));
    t.slot_start  = ($urandom_range(7) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
    t.slot_data   = 8'($urandom_range(0, 3));
    t.slot_recov  = ($urandom_range(7) == 0) ? 6'($urandom_range(0, 20)) : 6'($urandom_range(0, 2));
    t.conv_wait   = 20'($urandom_range(0, 6));
    return t;
  endfunction

  // keep feeding ticks until the sequencer copy is back to idle
  task automatic finish_sequence(int mode);
    logic s, d;
    do begin
      repeat (CHUNK) begin
        // a stray start is ignored while busy and starts a new read once idle
        s = (mode == DQ_RANDOM) && ($urandom_range(99) < 2);
        d = (mode == DQ_HIGH) ? 1'b1 : (mode == DQ_LOW) ? 1'b0 : 1'($urandom_range(1));
        push_tick(s, d);
      end
      while (accepted_count != pushed_count) @(negedge clk_i);
    end while (seq_phase != PH_IDLE);
  endtask

  task automatic run_sequence(int mode);
    repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'($urandom_range(1)));
    push_tick(1'b1, 1'($urandom_range(1)));
    finish_sequence(mode);
  endtask

  // wait for every output word, then let the pipeline drain
  task automatic settle();
    while (accepted_count != pushed_count || tick_results_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    owtr_cfg_t   t;
    int unsigned random_base;
    int unsigned leftover;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_n <= 1'b1;

    // directed: idle ticks, start, then start toggled while busy;
    // the reset pulse opens on the reset timings, then the sensor floats high
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    repeat (CHUNK) push_tick(1'b0, 1'b1);
    settle();

    // every register at its top value while the reset pulse is still low
    t.reset_low   = 10'h3FF;
    t.pres_wait   = 8'hFF;
    t.reset_recov = 8'hFF;
    t.slot_start  = 4'hF;
    t.slot_data   = 8'hFF;
    t.slot_recov  = 6'h3F;
    t.conv_wait   = 20'hFFFFF;
    program_timing(t);
    repeat (CHUNK) push_tick(1'b0, 1'b1);
    settle();

    // all timings zero: the pulse ends on the next tick and every timed phase
    // lasts one tick; no presence and an all-ones reading
    t = '0;
    program_timing(t);
    finish_sequence(DQ_HIGH);
    settle();

    // still all zero, bus held low: presence on both resets and a zero reading
    run_sequence(DQ_LOW);
    settle();

    // random short timings with random bus levels
    random_base = pushed_count;
    while (pushed_count - random_base < RANDOM_TICKS) begin
      t = random_timing();
      program_timing(t);
      repeat ($urandom_range(1, 2)) run_sequence(DQ_RANDOM);
      settle();
    end

    // expectations never matched by an output word count as failures
    leftover = tick_results_q.size();
    if (leftover != 0) begin
      mismatch_count += leftover;
      $display("%0d predicted output words never arrived", leftover);
    end

    $display("covered %0d tick words over %0d timing settings, %0d finished readings",
             accepted_count, setting_count, reading_count);
    $display("last reading %0d tenths, presence %0b, %0d mismatches",
             tenths_reg, presence_flag, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
